FILE: src/spn_pkg.sv
// Shared types, constants and lookup functions of the 16-bit SPN block cipher.
package spn_pkg;

	localparam int BLOCK_W      = 16;
	localparam int NIB_W        = 4;
	localparam int SBOX_COUNT   = 4;
	localparam int ROUNDS_W     = 4;
	// subkey index runs up to round_count + 1, so one bit more than a round count
	localparam int IDX_W        = ROUNDS_W + 1;
	localparam int KEY_W        = 16;
	localparam int KEY_WIDTH_DEF = 16;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_CIPHER_KEY  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_COUNT = 1'd1;

	localparam logic [ROUNDS_W-1:0] ROUND_COUNT_RST = 4'd4;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} spn_state_t;

	typedef enum logic [1:0] {
		OP_XOR,
		OP_ENC,
		OP_DEC
	} spn_op_t;

	typedef struct packed {
		spn_op_t op;
		logic    perm;
	} spn_round_ctrl_t;

	function automatic logic [NIB_W-1:0] sbox_fwd(input logic [NIB_W-1:0] x);
		logic [NIB_W-1:0] y;
		case (x)
			4'h0: y = 4'hE;
			4'h1: y = 4'h4;
			4'h2: y = 4'hD;
			4'h3: y = 4'h1;
			4'h4: y = 4'h2;
			4'h5: y = 4'hF;
			4'h6: y = 4'hB;
			4'h7: y = 4'h8;
			4'h8: y = 4'h3;
			4'h9: y = 4'hA;
			4'hA: y = 4'h6;
			4'hB: y = 4'hC;
			4'hC: y = 4'h5;
			4'hD: y = 4'h9;
			4'hE: y = 4'h0;
			4'hF: y = 4'h7;
			default: y = 4'h0;
		endcase
		return y;
	endfunction

	function automatic logic [NIB_W-1:0] sbox_inv(input logic [NIB_W-1:0] x);
		logic [NIB_W-1:0] y;
		case (x)
			4'h0: y = 4'hE;
			4'h1: y = 4'h3;
			4'h2: y = 4'h4;
			4'h3: y = 4'h8;
			4'h4: y = 4'h1;
			4'h5: y = 4'hC;
			4'h6: y = 4'hA;
			4'h7: y = 4'hF;
			4'h8: y = 4'h7;
			4'h9: y = 4'hD;
			4'hA: y = 4'h9;
			4'hB: y = 4'h6;
			4'hC: y = 4'hB;
			4'hD: y = 4'h2;
			4'hE: y = 4'h0;
			4'hF: y = 4'h5;
			default: y = 4'h0;
		endcase
		return y;
	endfunction

	function automatic logic [BLOCK_W-1:0] substitute(input logic [BLOCK_W-1:0] b,
			input logic inverse);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int i = 0; i < SBOX_COUNT; i++) begin
			if (inverse) begin
				r[i*NIB_W +: NIB_W] = sbox_inv(b[i*NIB_W +: NIB_W]);
			end else begin
				r[i*NIB_W +: NIB_W] = sbox_fwd(b[i*NIB_W +: NIB_W]);
			end
		end
		return r;
	endfunction

	// 4x4 transpose of the bit matrix; its own inverse
	function automatic logic [BLOCK_W-1:0] permute(input logic [BLOCK_W-1:0] b);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			r[NIB_W*(i % NIB_W) + i / NIB_W] = b[i];
		end
		return r;
	endfunction

endpackage

FILE: src/spn_chan_if.sv
// Valid/ready channels for request and result words of the SPN cipher.
interface spn_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [spn_pkg::BLOCK_W-1:0]  block_in;

	modport source (output valid, output req_type, output block_in, input ready);
	modport sink (input valid, input req_type, input block_in, output ready);
endinterface

interface spn_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [spn_pkg::BLOCK_W-1:0]  block_out;

	modport source (output valid, output block_out, input ready);
	modport sink (input valid, input block_out, output ready);
endinterface

FILE: src/spn_keysched.sv
// Round subkey generator: rotates the key by the accumulated 1,2,1,2... schedule.
module spn_keysched #(
	parameter int KEY_WIDTH = spn_pkg::KEY_WIDTH_DEF
) (
	input  logic [spn_pkg::KEY_W-1:0]   key,
	input  logic [spn_pkg::IDX_W-1:0]   idx,
	output logic [spn_pkg::BLOCK_W-1:0] subkey
);

	localparam int RW    = $clog2(KEY_WIDTH);
	localparam int TOT_W = RW + 1;

	logic [TOT_W-1:0]       total;
	logic [TOT_W-1:0]       wrapped;
	logic [RW-1:0]          amt;
	logic [KEY_WIDTH-1:0]   key_ext;
	logic [2*KEY_WIDTH-1:0] doubled;

	// total stays below twice the key width, so one subtract wraps it
	assign total   = TOT_W'(idx) + TOT_W'(idx >> 1);
	assign wrapped = (total >= TOT_W'(KEY_WIDTH)) ? total - TOT_W'(KEY_WIDTH) : total;
	assign amt     = wrapped[RW-1:0];

	assign key_ext = KEY_WIDTH'(key);
	assign doubled = {key_ext, key_ext} << amt;
	assign subkey  = doubled[KEY_WIDTH +: spn_pkg::BLOCK_W];

endmodule

FILE: src/spn_round.sv
// Shared round unit: key mix, forward or inverse substitution and transpose.
module spn_round (
	input  logic [spn_pkg::BLOCK_W-1:0] blk,
	input  logic [spn_pkg::BLOCK_W-1:0] subkey,
	input  spn_pkg::spn_round_ctrl_t    ctrl,
	output logic [spn_pkg::BLOCK_W-1:0] result
);

	logic [spn_pkg::BLOCK_W-1:0] enc_sub;
	logic [spn_pkg::BLOCK_W-1:0] dec_in;

	assign enc_sub = spn_pkg::substitute(blk ^ subkey, 1'b0);
	assign dec_in  = ctrl.perm ? spn_pkg::permute(blk) : blk;

	always_comb begin
		case (ctrl.op)
			spn_pkg::OP_XOR: result = blk ^ subkey;
			spn_pkg::OP_ENC: result = ctrl.perm ? spn_pkg::permute(enc_sub) : enc_sub;
			spn_pkg::OP_DEC: result = spn_pkg::substitute(dec_in, 1'b1) ^ subkey;
			default:         result = blk;
		endcase
	end

endmodule

FILE: src/spn_block_cipher16_unit.sv
// Top level of the 16-bit SPN block cipher: sequencer, registers and channels.
// One request word (req_type 0 encrypts, 1 decrypts) is taken while the unit is idle and then
// runs through a single shared round unit, one step per cycle except that the last step is
// held while the output register is still full: round_count rounds plus one key-mix step.
// The unit is busy until its last step, so no new request is taken before then. The result
// word sits in an output register, so the next request is taken while it waits to be read.
// The subkey of each step is the key rotated within KEY_WIDTH bits, produced alongside the
// round. cipher_key and round_count are to be written through the config port only while
// no request is in flight; the user is bound to this and the block itself does not enforce it.
module spn_block_cipher16_unit #(
	parameter int KEY_WIDTH = spn_pkg::KEY_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spn_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [spn_pkg::CFG_DATA_W-1:0]   cfg_data,
	spn_req_if.sink                          req,
	spn_rsp_if.source                        rsp
);

	spn_pkg::spn_state_t state_q, state_d;

	logic [spn_pkg::KEY_W-1:0]    key_q;
	logic [spn_pkg::ROUNDS_W-1:0] rounds_q;
	logic [spn_pkg::ROUNDS_W-1:0] step_q;
	logic                         dec_q;
	logic [spn_pkg::BLOCK_W-1:0]  blk_q;
	logic [spn_pkg::BLOCK_W-1:0]  out_q;
	logic                         out_valid_q;

	logic                          load;
	logic                          advance;
	logic                          finish;
	logic                          last;
	logic                          out_free;
	logic [spn_pkg::IDX_W-1:0]     idx;
	logic [spn_pkg::IDX_W-1:0]     rounds_p1;
	logic [spn_pkg::IDX_W-1:0]     step_p1;
	spn_pkg::spn_round_ctrl_t      ctrl;
	logic [spn_pkg::BLOCK_W-1:0]   subkey;
	logic [spn_pkg::BLOCK_W-1:0]   round_res;

	spn_keysched #(
		.KEY_WIDTH (KEY_WIDTH)
	) u_keysched (
		.key    (key_q),
		.idx    (idx),
		.subkey (subkey)
	);

	spn_round u_round (
		.blk    (blk_q),
		.subkey (subkey),
		.ctrl   (ctrl),
		.result (round_res)
	);

	assign last      = (step_q == rounds_q);
	assign out_free  = !out_valid_q || rsp.ready;
	assign rounds_p1 = spn_pkg::IDX_W'(rounds_q) + 1'b1;
	assign step_p1   = spn_pkg::IDX_W'(step_q) + 1'b1;

	// encrypt: rounds 1..R then the final key; decrypt: final key first, rounds R..1
	always_comb begin
		if (!dec_q) begin
			idx       = step_p1;
			ctrl.op   = last ? spn_pkg::OP_XOR : spn_pkg::OP_ENC;
			ctrl.perm = step_p1 < rounds_p1 - 1'b1;
		end else if (step_q == '0) begin
			idx       = rounds_p1;
			ctrl.op   = spn_pkg::OP_XOR;
			ctrl.perm = 1'b0;
		end else begin
			idx       = rounds_p1 - spn_pkg::IDX_W'(step_q);
			ctrl.op   = spn_pkg::OP_DEC;
			ctrl.perm = step_q > spn_pkg::ROUNDS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		advance   = 1'b0;
		finish    = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			spn_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					load    = 1'b1;
					state_d = spn_pkg::ST_RUN;
				end
			end
			spn_pkg::ST_RUN: begin
				if (!last) begin
					advance = 1'b1;
				end else if (out_free) begin
					// hold the last step until the output register can take the word
					finish  = 1'b1;
					state_d = spn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spn_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			rounds_q <= spn_pkg::ROUND_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				spn_pkg::CFG_CIPHER_KEY:  key_q    <= cfg_data[spn_pkg::KEY_W-1:0];
				spn_pkg::CFG_ROUND_COUNT: rounds_q <= cfg_data[spn_pkg::ROUNDS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (load) begin
			step_q <= '0;
		end else if (advance) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dec_q <= req.req_type;
			blk_q <= req.block_in;
		end else if (advance) begin
			blk_q <= round_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q <= round_res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.block_out = out_q;

endmodule
